>>> rtl/bb3_pkg.sv
// bb3_pkg: shared types and constants of the 3x3 RGB box blur.
// No dependencies; used by bb3_if.sv and box_blur_3x3_rgb_top.sv.
package bb3_pkg;

  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int RGBA_W     = 32;
  localparam int COL_OUT_W  = 10;
  localparam int ROW_OUT_W  = 10;
  localparam int SUM_W      = 12;
  localparam int DIV9_MUL_W = 13;
  localparam int DIV9_SHIFT = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  localparam logic [CFG_W-1:0]      WIDTH_RESET  = 11'd800;
  localparam logic [CFG_W-1:0]      HEIGHT_RESET = 11'd600;
  localparam logic [CHAN_W-1:0]     ALPHA        = 8'hFF;
  localparam logic [DIV9_MUL_W-1:0] DIV9_MUL     = 13'd7282;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [RGBA_W-1:0]    rgba_word;
    logic [COL_OUT_W-1:0] out_col;
    logic [ROW_OUT_W-1:0] out_row;
    logic                 frame_last;
  } out_item_t;

endpackage

>>> rtl/bb3_if.sv
// bb3_if: valid/ready channel interfaces for pixel requests and blurred results.
// Depends on bb3_pkg.
interface bb3_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [bb3_pkg::CHAN_W-1:0]  in_red;
  logic [bb3_pkg::CHAN_W-1:0]  in_green;
  logic [bb3_pkg::CHAN_W-1:0]  in_blue;

  modport source (output valid, mode, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, mode, in_red, in_green, in_blue, output ready);
endinterface

interface bb3_out_if;
  logic                          valid;
  logic                          ready;
  logic [bb3_pkg::RGBA_W-1:0]    rgba_word;
  logic [bb3_pkg::COL_OUT_W-1:0] out_col;
  logic [bb3_pkg::ROW_OUT_W-1:0] out_row;
  logic                          frame_last;

  modport source (output valid, rgba_word, out_col, out_row, frame_last, input ready);
  modport sink   (input valid, rgba_word, out_col, out_row, frame_last, output ready);
endinterface

>>> rtl/box_blur_3x3_rgb_top.sv
// box_blur_3x3_rgb_top: streaming 3x3 box blur over a two-row line memory.
// Depends on bb3_pkg and bb3_if.
//
//   channel  dir  handshake            payload
//   in_chan  in   valid/ready          mode, in_red, in_green, in_blue
//   out_chan out  valid/ready          rgba_word, out_col, out_row, frame_last
//   cfg      in   cfg_we (no wait)     cfg_index, cfg_wdata
//
// One request per cycle while in_chan.ready is high; a result passes through
// the line memory read, the window sum stage and the /9 multiply in turn.
// Read-after-write on one column (narrow frames, drain) is forwarded.
// rst_n is synchronous; the line memory keeps its contents and is not cleared.
// A four-entry result queue absorbs out_chan stalls; in_chan.ready drops when
// four results are outstanding.
module box_blur_3x3_rgb_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bb3_in_if.sink                        in_chan,
  bb3_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int VW    = RW + 1;
  localparam int XWW   = (CW > bb3_pkg::CFG_W) ? CW : bb3_pkg::CFG_W;
  localparam int XHW   = (RW > bb3_pkg::CFG_W) ? RW : bb3_pkg::CFG_W;
  localparam int SW    = bb3_pkg::SUM_W;
  localparam int PW    = bb3_pkg::SUM_W + bb3_pkg::DIV9_MUL_W;
  localparam int CH    = bb3_pkg::CHAN_W;
  localparam int PXW   = bb3_pkg::PIX_W;
  localparam int OCW   = bb3_pkg::COL_OUT_W;
  localparam int ORW   = bb3_pkg::ROW_OUT_W;
  localparam int FCW   = bb3_pkg::FIFO_CW;
  localparam int FAW   = bb3_pkg::FIFO_AW;
  localparam int FDEP  = bb3_pkg::FIFO_DEPTH;

  typedef struct packed {
    logic [AW-1:0]    addr;
    bb3_pkg::pix_t    pix;
    logic             vcol0;
    logic             emit;
    logic [2:0]       rows;
    logic [2:0]       cols;
    logic [ORW-1:0]   orow;
    logic [OCW-1:0]   ocol;
    logic             last;
  } s1_t;

  typedef struct packed {
    logic [SW-1:0]    sum_red;
    logic [SW-1:0]    sum_green;
    logic [SW-1:0]    sum_blue;
    logic [ORW-1:0]   orow;
    logic [OCW-1:0]   ocol;
    logic             last;
  } s2_t;

  // configuration
  logic [bb3_pkg::CFG_W-1:0] frame_width_r;
  logic [bb3_pkg::CFG_W-1:0] frame_height_r;
  logic [CW-1:0]             eff_w;
  logic [RW-1:0]             eff_h;

  // frame position
  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] drain_r, drain_nxt;

  // request decode
  logic          acc, acc_go, ignore, row_full;
  logic [VW-1:0] vrow;
  logic [AW-1:0] vcol;
  logic [VW-1:0] orow_full;
  logic [AW-1:0] ocol_full;
  s1_t           s1_nxt;

  // line memory: [2*PXW-1:PXW] upper row, [PXW-1:0] middle row
  logic [2*PXW-1:0] line_mem [MAX_WIDTH];
  logic [2*PXW-1:0] rd_data_r;
  logic             fwd_hit_r;
  logic [2*PXW-1:0] fwd_data_r;

  // window and stages
  logic                          s1_v_r;
  s1_t                           s1_r;
  bb3_pkg::pix_t [2:0][2:0]      win_r, win_nxt, win_src;
  bb3_pkg::pix_t                 top_cur, mid_cur;
  logic                          s2_v_r;
  s2_t                           s2_r, s2_nxt;
  logic [PW-1:0]                 prod_red, prod_green, prod_blue;
  bb3_pkg::out_item_t            push_item;

  // result queue
  bb3_pkg::out_item_t fifo_r [FDEP];
  logic [FAW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [FCW-1:0]     fcnt_r, cred_r, cred_nxt;
  logic               pop;

  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = CW'(1);
    end else if (XWW'(frame_width_r) > XWW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      eff_h = RW'(1);
    end else if (XHW'(frame_height_r) > XHW'(MAX_HEIGHT)) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(frame_height_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bb3_pkg::WIDTH_RESET;
      frame_height_r <= bb3_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bb3_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        bb3_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign acc    = in_chan.valid && in_chan.ready;
  assign acc_go = acc && !ignore;

  always_comb begin
    row_full  = row_r >= eff_h;
    col_nxt   = col_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    vrow      = VW'(row_r);
    vcol      = col_r;
    if (in_chan.mode == bb3_pkg::MODE_PIXEL) begin
      ignore    = row_full;
      drain_nxt = '0;
      if (CW'(col_r) + CW'(1) >= eff_w) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end else begin
      ignore = !row_full;
      if (drain_r < eff_w) begin
        vrow      = VW'(eff_h);
        vcol      = AW'(drain_r);
        drain_nxt = drain_r + CW'(1);
      end else begin
        vrow      = VW'(eff_h) + VW'(1);
        vcol      = '0;
        col_nxt   = '0;
        row_nxt   = '0;
        drain_nxt = '0;
      end
    end

    s1_nxt.addr  = vcol;
    s1_nxt.pix   = {in_chan.in_red, in_chan.in_green, in_chan.in_blue};
    s1_nxt.vcol0 = vcol == '0;
    if (vcol == '0) begin
      // center is the last column of the row before last
      s1_nxt.emit = vrow >= VW'(2);
      s1_nxt.rows = {(vrow - VW'(1)) < VW'(eff_h), 1'b1, vrow >= VW'(3)};
      s1_nxt.cols = {1'b1, eff_w >= CW'(2), 1'b0};
      orow_full   = vrow - VW'(2);
      ocol_full   = AW'(eff_w - CW'(1));
    end else begin
      s1_nxt.emit = vrow >= VW'(1);
      s1_nxt.rows = {vrow < VW'(eff_h), 1'b1, vrow >= VW'(2)};
      s1_nxt.cols = {1'b1, 1'b1, vcol >= AW'(2)};
      orow_full   = vrow - VW'(1);
      ocol_full   = vcol - AW'(1);
    end
    s1_nxt.orow = ORW'(orow_full);
    s1_nxt.ocol = OCW'(ocol_full);
    s1_nxt.last = (orow_full == VW'(eff_h) - VW'(1)) &&
                  (ocol_full == AW'(eff_w - CW'(1)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= '0;
    end else if (acc_go) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      drain_r <= drain_nxt;
    end
  end

  // line memory: write back at stage 1, read at request
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      line_mem[s1_r.addr] <= {mid_cur, s1_r.pix};
    end
    if (acc_go) begin
      rd_data_r  <= line_mem[vcol];
      fwd_hit_r  <= s1_v_r && (s1_r.addr == vcol);
      fwd_data_r <= {mid_cur, s1_r.pix};
    end
  end

  always_comb begin
    if (fwd_hit_r) begin
      top_cur = fwd_data_r[2*PXW-1:PXW];
      mid_cur = fwd_data_r[PXW-1:0];
    end else begin
      top_cur = rd_data_r[2*PXW-1:PXW];
      mid_cur = rd_data_r[PXW-1:0];
    end
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = top_cur;
    win_nxt[1][2] = mid_cur;
    win_nxt[2][2] = s1_r.pix;
    win_src = s1_r.vcol0 ? win_r : win_nxt;

    s2_nxt.sum_red   = '0;
    s2_nxt.sum_green = '0;
    s2_nxt.sum_blue  = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (s1_r.rows[r] && s1_r.cols[c]) begin
          s2_nxt.sum_red   = s2_nxt.sum_red   + SW'(win_src[r][c][2*CH +: CH]);
          s2_nxt.sum_green = s2_nxt.sum_green + SW'(win_src[r][c][CH +: CH]);
          s2_nxt.sum_blue  = s2_nxt.sum_blue  + SW'(win_src[r][c][0 +: CH]);
        end
      end
    end
    s2_nxt.orow = s1_r.orow;
    s2_nxt.ocol = s1_r.ocol;
    s2_nxt.last = s1_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      win_r <= '0;
    end else if (s1_v_r) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc_go;
      s2_v_r <= s1_v_r && s1_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_go) begin
      s1_r <= s1_nxt;
    end
    if (s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  // divide by 9: multiply by reciprocal, exact for sums up to 9*255
  always_comb begin
    prod_red   = PW'(s2_r.sum_red)   * PW'(bb3_pkg::DIV9_MUL);
    prod_green = PW'(s2_r.sum_green) * PW'(bb3_pkg::DIV9_MUL);
    prod_blue  = PW'(s2_r.sum_blue)  * PW'(bb3_pkg::DIV9_MUL);
    push_item.rgba_word  = {prod_red[bb3_pkg::DIV9_SHIFT +: CH],
                            prod_green[bb3_pkg::DIV9_SHIFT +: CH],
                            prod_blue[bb3_pkg::DIV9_SHIFT +: CH],
                            bb3_pkg::ALPHA};
    push_item.out_col    = s2_r.ocol;
    push_item.out_row    = s2_r.orow;
    push_item.frame_last = s2_r.last;
  end

  // result queue and request credit
  assign pop      = out_chan.valid && out_chan.ready;
  assign cred_nxt = cred_r + FCW'(acc_go && s1_nxt.emit) - FCW'(pop);
  assign in_chan.ready = cred_r < FCW'(FDEP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
      cred_r   <= '0;
    end else begin
      cred_r <= cred_nxt;
      fcnt_r <= fcnt_r + FCW'(s2_v_r) - FCW'(pop);
      if (s2_v_r) begin
        wr_ptr_r <= wr_ptr_r + FAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      fifo_r[wr_ptr_r] <= push_item;
    end
  end

  assign out_chan.valid      = fcnt_r != '0;
  assign out_chan.rgba_word  = fifo_r[rd_ptr_r].rgba_word;
  assign out_chan.out_col    = fifo_r[rd_ptr_r].out_col;
  assign out_chan.out_row    = fifo_r[rd_ptr_r].out_row;
  assign out_chan.frame_last = fifo_r[rd_ptr_r].frame_last;

endmodule
